[sv/bll_pkg.sv]
package bll_pkg;

    localparam int unsigned HDR_BYTES = 5;

    localparam logic [7:0]  TYPE_DATA      = 8'h00;
    localparam logic [7:0]  TYPE_END       = 8'hFF;
    localparam logic [15:0] MAX_EXEC_RESET = 16'h7FFF;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_XFER  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [7:0]  data;
    } t_result;

endpackage

[sv/bll_parser.sv]
module bll_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    input  logic            i_restart,
    input  logic [15:0]     i_max_exec,
    output logic            o_res_vld,
    output bll_pkg::t_result o_res
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    localparam logic [2:0] LAST_HDR = 3'(bll_pkg::HDR_BYTES - 1);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [15:0] r_addr, n_addr;

    t_phase      cur_phase;
    logic [2:0]  cur_cnt;
    logic [15:0] len_dec;
    logic        emit;
    bll_pkg::t_result res;

    always_comb begin
        cur_phase = i_restart ? PH_HEADER : r_phase;
        cur_cnt   = i_restart ? 3'd0 : r_hdr_cnt;
        len_dec   = r_len - 16'd1;
        n_phase   = cur_phase;
        n_hdr_cnt = cur_cnt;
        n_type    = r_type;
        n_len     = r_len;
        n_addr    = r_addr;
        emit      = 1'b0;
        res       = '{kind: bll_pkg::KIND_WRITE, address: 16'd0, data: 8'd0};
        unique case (cur_phase)
            PH_DATA: begin
                emit    = 1'b1;
                res     = '{kind: bll_pkg::KIND_WRITE, address: r_addr, data: i_byte};
                n_addr  = r_addr + 16'd1;
                n_len   = len_dec;
                if (len_dec == 16'd0) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                case (cur_cnt)
                    3'd0:    n_type = i_byte;
                    3'd1:    n_len  = {i_byte, r_len[7:0]};
                    3'd2:    n_len  = {r_len[15:8], i_byte};
                    3'd3:    n_addr = {i_byte, r_addr[7:0]};
                    default: n_addr = {r_addr[15:8], i_byte};
                endcase
                if (cur_cnt < LAST_HDR) begin
                    n_hdr_cnt = cur_cnt + 3'd1;
                end else begin
                    n_hdr_cnt = 3'd0;
                    if (n_type == bll_pkg::TYPE_DATA) begin
                        n_phase = (n_len != 16'd0) ? PH_DATA : PH_HEADER;
                    end else begin
                        n_phase = PH_DONE;
                        emit    = 1'b1;
                        if (n_type == bll_pkg::TYPE_END && n_addr != 16'd0 &&
                            n_addr <= i_max_exec && n_len == 16'd0) begin
                            res = '{kind: bll_pkg::KIND_XFER, address: n_addr, data: 8'd0};
                        end else begin
                            res = '{kind: bll_pkg::KIND_ERROR, address: 16'd0, data: 8'd0};
                        end
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= 3'd0;
            r_type    <= 8'd0;
            r_len     <= 16'd0;
            r_addr    <= 16'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_type    <= n_type;
            r_len     <= n_len;
            r_addr    <= n_addr;
        end
    end

    assign o_res_vld = i_step && emit;
    assign o_res     = res;

endmodule

[sv/bll_out_reg.sv]
module bll_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bll_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_vld,
    output bll_pkg::t_result o_res
);

    logic             r_vld;
    bll_pkg::t_result r_res;

    assign o_free = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

[sv/binary_load_record_parser.sv]
// path: each input byte passes the input register, then its result the result register,
// before the result can be taken; a stalled output side holds it in the result register
// throughput: one byte per cycle while the output side takes results
// reset (synchronous, active low): clears both valid flags and the parser state,
// sets max_exec_address to 32767
module binary_load_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // stream_byte
    input  logic [0:0]  s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // address[15:0], data[23:16]
    output logic [1:0]  m_axis_tuser,   // kind
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    logic [15:0] r_max_exec;
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_restart;

    logic             step;
    logic             out_free;
    logic             res_vld;
    bll_pkg::t_result res;
    bll_pkg::t_result out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_exec <= bll_pkg::MAX_EXEC_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_exec <= i_cfg_wr_data;
        end
    end

    assign step          = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte    <= s_axis_tdata;
            r_in_restart <= s_axis_tuser[0];
        end
    end

    bll_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .i_restart  (r_in_restart),
        .i_max_exec (r_max_exec),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    bll_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_vld),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_free  (out_free),
        .o_vld   (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {out_res.data, out_res.address};
    assign m_axis_tuser = out_res.kind;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while stage and output are both stalled");

    a_xfer_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == bll_pkg::KIND_XFER) |->
        (m_axis_tdata[15:0] != 16'd0 && m_axis_tdata[15:0] <= r_max_exec &&
         m_axis_tdata[23:16] == 8'd0))
        else $error("transfer result outside accepted address range");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == bll_pkg::KIND_ERROR) |-> m_axis_tdata == 24'd0)
        else $error("error result carries nonzero payload");

endmodule
